FILE: rtl/core/lpd_pkg.sv
// shared types and constants of the led pattern driver
package lpd_pkg;

    // input and output field widths
    localparam int CHAN_W      = 3;
    localparam int CMD_W       = 4;
    localparam int OUT_W       = 7;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 16;
    localparam int CFG_W       = 16;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    // command queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QA_W    = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef logic [CMD_W-1:0] t_cmd;

    // level commands
    localparam t_cmd CMD_OFF       = 4'd0;
    localparam t_cmd CMD_ON        = 4'd1;
    localparam t_cmd CMD_BLINK_OFF = 4'd2;
    localparam t_cmd CMD_BLINK_ON  = 4'd3;
    localparam t_cmd CMD_PULSE_OFF = 4'd4;
    localparam t_cmd CMD_PULSE_ON  = 4'd5;
    localparam t_cmd CMD_DUTY_OFF  = 4'd6;
    localparam t_cmd CMD_DUTY_ON   = 4'd7;
    localparam t_cmd CMD_TWIN_OFF  = 4'd8;
    localparam t_cmd CMD_TWIN_ON   = 4'd9;

    // classified operation carried through the queue
    typedef enum logic [1:0] {
        OP_TICK,
        OP_LATCH,
        OP_IGNORE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAN_W-1:0] chan;
        t_cmd              cmd;
    } t_item;

    // configuration register contents
    typedef struct packed {
        logic [CFG_W-1:0] blink_half;
        logic [CFG_W-1:0] pulse_half;
        logic [CFG_W-1:0] duty_on;
        logic [CFG_W-1:0] duty_off;
        logic [CFG_W-1:0] short_pulse;
        logic [CFG_W-1:0] long_pulse;
        logic [OUT_W-1:0] active_low;
    } t_cfg;

endpackage

FILE: rtl/core/lpd_regs.sv
// apb configuration registers of the led pattern driver
module lpd_regs
    import lpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output t_cfg                  o_cfg
);

    typedef enum logic [2:0] {
        REG_BLINK_HALF,
        REG_PULSE_HALF,
        REG_DUTY_ON,
        REG_DUTY_OFF,
        REG_SHORT_PULSE,
        REG_LONG_PULSE,
        REG_ACTIVE_LOW
    } t_reg;

    t_cfg r_cfg;
    t_reg reg_sel;

    assign reg_sel = t_reg'(paddr[APB_ADDR_W-1:2]);
    assign o_cfg   = r_cfg;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_half  <= 16'd300;
            r_cfg.pulse_half  <= 16'd1000;
            r_cfg.duty_on     <= 16'd700;
            r_cfg.duty_off    <= 16'd300;
            r_cfg.short_pulse <= 16'd300;
            r_cfg.long_pulse  <= 16'd600;
            r_cfg.active_low  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_BLINK_HALF:  r_cfg.blink_half  <= pwdata[CFG_W-1:0];
                REG_PULSE_HALF:  r_cfg.pulse_half  <= pwdata[CFG_W-1:0];
                REG_DUTY_ON:     r_cfg.duty_on     <= pwdata[CFG_W-1:0];
                REG_DUTY_OFF:    r_cfg.duty_off    <= pwdata[CFG_W-1:0];
                REG_SHORT_PULSE: r_cfg.short_pulse <= pwdata[CFG_W-1:0];
                REG_LONG_PULSE:  r_cfg.long_pulse  <= pwdata[CFG_W-1:0];
                REG_ACTIVE_LOW:  r_cfg.active_low  <= pwdata[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_BLINK_HALF:  prdata = APB_DATA_W'(r_cfg.blink_half);
            REG_PULSE_HALF:  prdata = APB_DATA_W'(r_cfg.pulse_half);
            REG_DUTY_ON:     prdata = APB_DATA_W'(r_cfg.duty_on);
            REG_DUTY_OFF:    prdata = APB_DATA_W'(r_cfg.duty_off);
            REG_SHORT_PULSE: prdata = APB_DATA_W'(r_cfg.short_pulse);
            REG_LONG_PULSE:  prdata = APB_DATA_W'(r_cfg.long_pulse);
            REG_ACTIVE_LOW:  prdata = APB_DATA_W'(r_cfg.active_low);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/lpd_front.sv
// input side: accepts items, classifies them and queues them for the back end
module lpd_front
    import lpd_pkg::*;
#(
    parameter int CHANNELS = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_user,
    output logic                 o_q_valid,
    output t_item                o_q_item,
    input  logic                 i_q_pop
);

    t_item             r_q [QDEPTH];
    logic [QA_W-1:0]   r_wr;
    logic [QA_W-1:0]   r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;
    t_item             cls_item;
    logic [CHAN_W-1:0] in_chan;
    t_cmd              in_cmd;

    assign in_chan = i_data[CHAN_W-1:0];
    assign in_cmd  = i_data[CHAN_W+CMD_W-1:CHAN_W];

    // classify: tick, valid latch, or a latch that changes nothing
    always_comb begin
        cls_item.chan = in_chan;
        cls_item.cmd  = in_cmd;
        if (!i_user) begin
            cls_item.op = OP_TICK;
        end else if ((32'(in_chan) < CHANNELS) && (in_cmd <= CMD_TWIN_ON)) begin
            cls_item.op = OP_LATCH;
        end else begin
            cls_item.op = OP_IGNORE;
        end
    end

    assign o_ready   = (r_cnt != QCNT_W'(QDEPTH));
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls_item;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QA_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QA_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/core/lpd_back.sv
// back end: applies latches and steps the channels one per cycle on a tick
module lpd_back
    import lpd_pkg::*;
#(
    parameter int CHANNELS   = 7,
    parameter int TIMER_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_busy,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_pin_levels,
    output logic [OUT_W-1:0] o_lit_mask
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LIT_W = (CHANNELS > OUT_W) ? CHANNELS : OUT_W;
    localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(CHANNELS - 1);
    localparam logic [OUT_W-1:0] CHAN_MSK =
        (CHANNELS >= OUT_W) ? {OUT_W{1'b1}} : OUT_W'((1 << CHANNELS) - 1);

    typedef enum logic [2:0] {
        MODE_OFF,
        MODE_ON,
        MODE_BLINK,
        MODE_PULSE,
        MODE_DUTY,
        MODE_TWIN
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_RESULT
    } t_state;

    // per-channel state
    t_mode                 r_mode  [CHANNELS];
    t_cmd                  r_cmd   [CHANNELS];
    logic [TIMER_BITS-1:0] r_timer [CHANNELS];
    logic [1:0]            r_phase [CHANNELS];
    logic [CHANNELS-1:0]   r_lit;

    t_state           r_state;
    logic [CH_W-1:0]  r_idx;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_pin;
    logic [OUT_W-1:0] r_litm;

    logic                  out_free;
    logic [TIMER_BITS-1:0] len_blink;
    logic [TIMER_BITS-1:0] len_pulse;
    logic [TIMER_BITS-1:0] len_don;
    logic [TIMER_BITS-1:0] len_doff;
    logic [TIMER_BITS-1:0] len_short;
    logic [TIMER_BITS-1:0] len_long;
    logic [LIT_W-1:0]      lit_pad;
    logic [OUT_W-1:0]      lit7;

    t_mode                 cur_m;
    t_cmd                  cur_c;
    logic [TIMER_BITS-1:0] cur_t;
    logic [1:0]            cur_p;
    logic                  cur_l;

    t_mode                 n_m;
    logic [TIMER_BITS-1:0] n_t;
    logic [1:0]            n_p;
    logic                  n_l;

    // phase lengths truncated or extended to the timer width
    assign len_blink = TIMER_BITS'(i_cfg.blink_half);
    assign len_pulse = TIMER_BITS'(i_cfg.pulse_half);
    assign len_don   = TIMER_BITS'(i_cfg.duty_on);
    assign len_doff  = TIMER_BITS'(i_cfg.duty_off);
    assign len_short = TIMER_BITS'(i_cfg.short_pulse);
    assign len_long  = TIMER_BITS'(i_cfg.long_pulse);

    assign cur_m = r_mode[r_idx];
    assign cur_c = r_cmd[r_idx];
    assign cur_t = r_timer[r_idx];
    assign cur_p = r_phase[r_idx];
    assign cur_l = r_lit[r_idx];

    // one channel update per cycle
    always_comb begin
        logic [TIMER_BITS-1:0] on_len;
        logic [TIMER_BITS-1:0] off_len;
        t_cmd                  off_cmd;
        n_m     = cur_m;
        n_t     = cur_t;
        n_p     = cur_p;
        n_l     = cur_l;
        on_len  = len_don;
        off_len = len_doff;
        off_cmd = CMD_DUTY_OFF;
        unique case (cur_m)
            MODE_OFF: begin
                if (cur_c == CMD_ON) begin
                    n_l = 1'b1;
                    n_m = MODE_ON;
                end else if (cur_c == CMD_BLINK_ON) begin
                    n_l = 1'b1;
                    n_t = len_blink;
                    n_m = MODE_BLINK;
                end else if (cur_c == CMD_PULSE_ON) begin
                    n_l = 1'b1;
                    n_t = len_pulse;
                    n_m = MODE_PULSE;
                end else if (cur_c == CMD_DUTY_ON) begin
                    n_l = 1'b1;
                    n_t = len_don;
                    n_m = MODE_DUTY;
                end else if (cur_c == CMD_TWIN_ON) begin
                    n_l = 1'b1;
                    n_t = len_short;
                    n_m = MODE_TWIN;
                    n_p = 2'd1;
                end
            end
            MODE_ON: begin
                if (cur_c == CMD_OFF) begin
                    n_l = 1'b0;
                    n_m = MODE_OFF;
                end
            end
            MODE_BLINK, MODE_PULSE, MODE_DUTY: begin
                if (cur_m == MODE_BLINK) begin
                    on_len  = len_blink;
                    off_len = len_blink;
                    off_cmd = CMD_BLINK_OFF;
                end else if (cur_m == MODE_PULSE) begin
                    on_len  = len_pulse;
                    off_len = len_pulse;
                    off_cmd = CMD_PULSE_OFF;
                end
                if (n_t != '0) begin
                    n_t = n_t - TIMER_BITS'(1);
                end
                // dark phase expired: light up
                if (n_t == '0 && !n_l) begin
                    n_t = on_len;
                    n_l = 1'b1;
                end
                // lit phase expired: go dark
                if (n_t == '0 && n_l) begin
                    n_t = off_len;
                    n_l = 1'b0;
                end
                if (cur_c == off_cmd) begin
                    n_t = '0;
                    n_l = 1'b0;
                    n_p = 2'd0;
                    n_m = MODE_OFF;
                end
            end
            MODE_TWIN: begin
                if (n_t != '0) begin
                    n_t = n_t - TIMER_BITS'(1);
                end
                // short gap over: start long pulse
                if (n_t == '0 && !n_l && n_p == 2'd1) begin
                    n_t = len_long;
                    n_l = 1'b1;
                    n_p = 2'd2;
                end
                // long pulse over: long gap
                if (n_t == '0 && n_l && n_p == 2'd2) begin
                    n_t = len_long;
                    n_l = 1'b0;
                end
                // short pulse over: short gap
                if (n_t == '0 && n_l && n_p == 2'd1) begin
                    n_t = len_short;
                    n_l = 1'b0;
                end
                // long gap over: start short pulse
                if (n_t == '0 && !n_l && n_p == 2'd2) begin
                    n_t = len_short;
                    n_l = 1'b1;
                    n_p = 2'd1;
                end
                if (cur_c == CMD_TWIN_OFF) begin
                    n_t = '0;
                    n_l = 1'b0;
                    n_p = 2'd0;
                    n_m = MODE_OFF;
                end
            end
            default: ;
        endcase
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_busy   = (r_state != S_IDLE);

    // visible lit flags of the first output channels
    assign lit_pad = LIT_W'(r_lit);
    assign lit7    = lit_pad[OUT_W-1:0] & CHAN_MSK;

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_pin       <= '0;
            r_litm      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_item.op == OP_TICK) begin
                            r_state <= S_TICK;
                            r_idx   <= '0;
                        end else begin
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_TICK: begin
                    if (r_idx == LAST_CH) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_idx <= r_idx + CH_W'(1);
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
                r_litm      <= lit7;
                r_pin       <= (lit7 ^ i_cfg.active_low) & CHAN_MSK;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // channel state: command latch and tick write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_mode[i]  <= MODE_OFF;
                r_cmd[i]   <= CMD_BLINK_OFF;
                r_timer[i] <= '0;
                r_phase[i] <= 2'd0;
            end
            r_lit <= '0;
        end else begin
            if (o_q_pop && i_q_item.op == OP_LATCH) begin
                r_cmd[CH_W'(i_q_item.chan)] <= i_q_item.cmd;
            end
            if (r_state == S_TICK) begin
                r_mode[r_idx]  <= n_m;
                r_timer[r_idx] <= n_t;
                r_phase[r_idx] <= n_p;
                r_lit[r_idx]   <= n_l;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pin_levels = r_pin;
    assign o_lit_mask   = r_litm;

endmodule

FILE: rtl/core/multi_channel_led_pattern_driver.sv
// Top level: LED pattern driver with stream input/output and APB registers.
// A command item goes from the input queue to the result state and then the output
// register; a tick item first runs the tick state, where the channel update unit steps
// one channel per cycle. The result state waits for a free output register. One item is
// worked at a time; up to 4 items wait in the input queue. Reset is synchronous, active
// low: registers return to their defaults, every channel goes to off, no clear pass.
module multi_channel_led_pattern_driver
    import lpd_pkg::*;
#(
    parameter int CHANNELS   = 7,
    parameter int TIMER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // stream input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // channel[2:0], command[6:3], zero pad
    input  logic [0:0]            s_tuser,   // action[0]
    // stream output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // pin_levels[6:0], lit_mask[13:7], zero pad
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int OUT_PAD = OUT_DATA_W - 2 * OUT_W;

    t_cfg             cfg;
    logic             q_valid;
    t_item            q_item;
    logic             q_pop;
    logic             back_busy;
    logic [OUT_W-1:0] pin_levels;
    logic [OUT_W-1:0] lit_mask;

    assign pready = 1'b1;

    // configuration registers
    lpd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // accept and classify
    lpd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_data    (s_tdata),
        .i_user    (s_tuser[0]),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    // channel sequencing and result
    lpd_back #(
        .CHANNELS   (CHANNELS),
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_busy       (back_busy),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_pin_levels (pin_levels),
        .o_lit_mask   (lit_mask)
    );

    assign m_tdata = {{OUT_PAD{1'b0}}, lit_mask, pin_levels};

`ifndef SYNTH
    // queue is empty and ready right after reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_tready)
        else $error("input not ready after reset");

    // back end never takes from an empty queue
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // no result appears without work in progress
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_valid && !back_busy && !m_tvalid) |=> !m_tvalid)
        else $error("result without an item");
`endif

endmodule
